@@ rtl/cpr_pkg.sv @@
`default_nettype none
package cpr_pkg;

	localparam int unsigned ZW         = 23;
	localparam int unsigned RW         = 15;
	localparam int unsigned VW         = 32;
	localparam int unsigned ROOTW      = 16;
	localparam int unsigned REMW       = 20;
	localparam int unsigned NCELL      = 16;
	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 24;

	localparam logic [RW-1:0] TIP_RADIUS = 15'd128;

	typedef enum logic [2:0] {
		SHAPE_FLAT    = 3'd0,
		SHAPE_BALL    = 3'd1,
		SHAPE_BULL    = 3'd2,
		SHAPE_CHAMFER = 3'd3,
		SHAPE_DRILL   = 3'd4,
		SHAPE_TAPER   = 3'd5
	} shape_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_TOOL_SHAPE    = 3'd0,
		CFG_TOOL_DIAMETER = 3'd1,
		CFG_CORNER_RAD    = 3'd2,
		CFG_TAN_HALF_TIP  = 3'd3,
		CFG_TAN_TAPER     = 3'd4
	} cfg_reg_t;

	typedef struct packed {
		logic [2:0]  shape;
		logic [15:0] diameter;
		logic [15:0] corner;
		logic [23:0] tan_tip;
		logic [23:0] tan_taper;
	} cfg_t;

	// result = addend + (use_root ? root : 0)
	typedef struct packed {
		logic          use_root;
		logic [RW-1:0] addend;
	} side_t;

	typedef struct packed {
		logic [VW-1:0]    v;
		logic [ROOTW-1:0] root;
		logic [REMW-1:0]  rem;
		side_t            side;
	} cell_t;

endpackage
`default_nettype wire

@@ rtl/cpr_front.sv @@
`default_nettype none
module cpr_front (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire cpr_pkg::cfg_t  cfg,
	input  wire logic           in_valid,
	output logic                in_ready,
	input  wire logic [23:0]    height,
	output logic                out_valid,
	input  wire logic           out_ready,
	output cpr_pkg::cell_t      out_data
);

	logic valid_s1, valid_s2, valid_s3, valid_s4;
	logic load_1, load_2, load_3, load_4;

	assign load_4   = !valid_s4 || out_ready;
	assign load_3   = !valid_s3 || load_4;
	assign load_2   = !valid_s2 || load_3;
	assign load_1   = !valid_s1 || load_2;
	assign in_ready = load_1;

	logic [cpr_pkg::RW-1:0] r, cr, c;
	logic [23:0]            tan_sel;

	assign r       = cfg.diameter[15:1];
	assign cr      = (cfg.corner < {1'b0, r}) ? cfg.corner[14:0] : r;
	assign c       = (cfg.shape == cpr_pkg::SHAPE_BALL) ? r : cr;
	assign tan_sel = (cfg.shape == cpr_pkg::SHAPE_TAPER) ? cfg.tan_taper : cfg.tan_tip;

	// stage 1: capture
	logic                   neg_s1;
	logic [cpr_pkg::ZW-1:0] z_s1;

	// stage 2: arc operands, cone partial products
	logic                   neg_s2, arc_s2;
	logic [14:0]            zc_s2;
	logic [15:0]            d_s2;
	logic [34:0]            pl_s2, ph_s2;

	logic        arc_c;
	logic [15:0] d_c;
	logic [34:0] pl_c, ph_c;

	assign arc_c = !neg_s1 && (z_s1 <= {8'b0, c});
	assign d_c   = {c, 1'b0} - {1'b0, z_s1[14:0]};
	assign pl_c  = {12'b0, z_s1} * {23'b0, tan_sel[11:0]};
	assign ph_c  = {12'b0, z_s1} * {23'b0, tan_sel[23:12]};

	// stage 3: sqrt argument, cone product
	logic        neg_s3, arc_s3;
	logic [31:0] v_s3;
	logic [30:0] p_s3;
	logic [46:0] psum_c;

	assign psum_c = {ph_s2, 12'b0} + {12'b0, pl_s2};

	// stage 4: per-shape selection
	logic [cpr_pkg::RW-1:0] base_c, cone_sat_c;
	logic [31:0]            cone_c;
	cpr_pkg::side_t         side_c;
	cpr_pkg::cell_t         cell_s4;

	assign base_c     = (cfg.shape == cpr_pkg::SHAPE_TAPER) ? cpr_pkg::TIP_RADIUS : '0;
	assign cone_c     = {1'b0, p_s3} + {17'b0, base_c};
	assign cone_sat_c = (cone_c < {17'b0, r}) ? cone_c[14:0] : r;

	always_comb begin
		side_c.use_root = 1'b0;
		side_c.addend   = r;
		if (neg_s3) begin
			side_c.addend = '0;
		end else begin
			case (cfg.shape) inside
				cpr_pkg::SHAPE_BALL: begin
					if (arc_s3) begin
						side_c.use_root = 1'b1;
						side_c.addend   = '0;
					end
				end
				cpr_pkg::SHAPE_BULL: begin
					if (arc_s3) begin
						side_c.use_root = 1'b1;
						side_c.addend   = r - cr;
					end
				end
				cpr_pkg::SHAPE_CHAMFER, cpr_pkg::SHAPE_DRILL, cpr_pkg::SHAPE_TAPER: begin
					side_c.addend = cone_sat_c;
				end
				default: begin
					side_c.addend = r;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			if (load_1) valid_s1 <= in_valid;
			if (load_2) valid_s2 <= valid_s1;
			if (load_3) valid_s3 <= valid_s2;
			if (load_4) valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (load_1) begin
			neg_s1 <= height[23];
			z_s1   <= height[22:0];
		end
		if (load_2) begin
			neg_s2 <= neg_s1;
			arc_s2 <= arc_c;
			zc_s2  <= z_s1[14:0];
			d_s2   <= d_c;
			pl_s2  <= pl_c;
			ph_s2  <= ph_c;
		end
		if (load_3) begin
			neg_s3 <= neg_s2;
			arc_s3 <= arc_s2;
			v_s3   <= {17'b0, zc_s2} * {16'b0, d_s2};
			p_s3   <= psum_c[46:16];
		end
		if (load_4) begin
			cell_s4.v    <= v_s3;
			cell_s4.root <= '0;
			cell_s4.rem  <= '0;
			cell_s4.side <= side_c;
		end
	end

	assign out_valid = valid_s4;
	assign out_data  = cell_s4;

endmodule
`default_nettype wire

@@ rtl/cpr_sqrt_cell.sv @@
`default_nettype none
module cpr_sqrt_cell (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           up_valid,
	output logic                up_ready,
	input  wire cpr_pkg::cell_t up,
	output logic                dn_valid,
	input  wire logic           dn_ready,
	output cpr_pkg::cell_t      dn
);

	logic                      valid_q;
	cpr_pkg::cell_t            cell_q;
	cpr_pkg::cell_t            next_c;
	logic [cpr_pkg::REMW-1:0]  rem_sh, trial;
	logic                      ge;

	// one root digit per cell: bring down two bits, try (root*4 + 1)
	assign rem_sh = {up.rem[cpr_pkg::REMW-3:0], up.v[cpr_pkg::VW-1 -: 2]};
	assign trial  = {2'b00, up.root, 2'b01};
	assign ge     = rem_sh >= trial;

	always_comb begin
		next_c.v    = {up.v[cpr_pkg::VW-3:0], 2'b00};
		next_c.root = {up.root[cpr_pkg::ROOTW-2:0], ge};
		next_c.rem  = ge ? (rem_sh - trial) : rem_sh;
		next_c.side = up.side;
	end

	assign up_ready = !valid_q || dn_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (up_ready) begin
			valid_q <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_ready) cell_q <= next_c;
	end

	assign dn_valid = valid_q;
	assign dn       = cell_q;

endmodule
`default_nettype wire

@@ rtl/cutter_profile_radius.sv @@
// Pipeline: 4 front stages, 16 square-root cells, 1 output register between height and radius.
// Throughput: one request per cycle while the output is not stalled by out_ready.
// Each stage holds its request until the next one frees, so bubbles are filled under stall.
// Reset (arst_n low, asynchronous) empties the pipeline and loads the default tool:
// flat endmill, 6 mm diameter, tangents as documented.
`default_nettype none
module cutter_profile_radius (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             in_valid,
	output logic                                  in_ready,
	input  wire logic [23:0]                      height,
	output logic                                  out_valid,
	input  wire logic                             out_ready,
	output logic [14:0]                           radius_out,
	input  wire logic                             cfg_valid,
	output logic                                  cfg_ready,
	input  wire logic [cpr_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [cpr_pkg::CFG_DATA_W-1:0]   cfg_data
);

	cpr_pkg::cfg_t cfg_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.shape     <= cpr_pkg::SHAPE_FLAT;
			cfg_q.diameter  <= 16'd1536;
			cfg_q.corner    <= 16'd0;
			cfg_q.tan_tip   <= 24'd109073;
			cfg_q.tan_taper <= 24'd3435;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				cpr_pkg::CFG_TOOL_SHAPE:    cfg_q.shape     <= cfg_data[2:0];
				cpr_pkg::CFG_TOOL_DIAMETER: cfg_q.diameter  <= cfg_data[15:0];
				cpr_pkg::CFG_CORNER_RAD:    cfg_q.corner    <= cfg_data[15:0];
				cpr_pkg::CFG_TAN_HALF_TIP:  cfg_q.tan_tip   <= cfg_data;
				cpr_pkg::CFG_TAN_TAPER:     cfg_q.tan_taper <= cfg_data;
				default: ;
			endcase
		end
	end

	cpr_pkg::cell_t link [0:cpr_pkg::NCELL];
	logic           link_valid [0:cpr_pkg::NCELL];
	logic           link_ready [0:cpr_pkg::NCELL];

	cpr_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.height    (height),
		.out_valid (link_valid[0]),
		.out_ready (link_ready[0]),
		.out_data  (link[0])
	);

	for (genvar i = 0; i < cpr_pkg::NCELL; i++) begin : g_cell
		cpr_sqrt_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.up_valid (link_valid[i]),
			.up_ready (link_ready[i]),
			.up       (link[i]),
			.dn_valid (link_valid[i+1]),
			.dn_ready (link_ready[i+1]),
			.dn       (link[i+1])
		);
	end

	logic                   out_valid_q;
	logic [cpr_pkg::RW-1:0] radius_q;
	logic                   out_load;
	logic [cpr_pkg::RW-1:0] root_term;

	assign out_load   = !out_valid_q || out_ready;
	assign link_ready[cpr_pkg::NCELL] = out_load;
	assign root_term  = link[cpr_pkg::NCELL].side.use_root ?
	                    link[cpr_pkg::NCELL].root[cpr_pkg::RW-1:0] : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= link_valid[cpr_pkg::NCELL];
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) radius_q <= link[cpr_pkg::NCELL].side.addend + root_term;
	end

	assign out_valid  = out_valid_q;
	assign radius_out = radius_q;

	// a full pipeline is the only reason to refuse a request
	a_ready_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (out_valid && !out_ready))
		else $error("in_ready low while output not stalled");

	// digit recurrence leaves remainder <= 2*root
	a_sqrt_remainder: assert property (@(posedge clk) disable iff (!arst_n)
		link_valid[cpr_pkg::NCELL] |->
			(link[cpr_pkg::NCELL].rem <= {3'b000, link[cpr_pkg::NCELL].root, 1'b0}))
		else $error("square root remainder out of range");

	// a stalled chain end must not change while output is blocked
	a_chain_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(link_valid[cpr_pkg::NCELL] && !out_load) |=>
			(link_valid[cpr_pkg::NCELL] && $stable(link[cpr_pkg::NCELL])))
		else $error("chain output changed under stall");

endmodule
`default_nettype wire
